>>> rtl/sgbu_pkg.sv
// Package for the softmax gradient bandit update core.
// Holds the item structs, register addresses and the 2^(-j/16) table.
package sgbu_pkg;

  typedef struct packed {
    logic               mode;
    logic [2:0]         arm_index;
    logic               reward;
    logic signed [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_arm;
    logic signed [15:0] preference;
    logic [15:0]        probability;
    logic               last;
  } out_item_t;

  localparam logic [1:0] REG_ACTIVE_ARMS = 2'd0;
  localparam logic [1:0] REG_STEP_SIZE   = 2'd1;
  localparam logic [1:0] REG_INV_TEMP    = 2'd2;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // 2^(-j/16) in Q.16, j = 0..16
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50536;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/sgbu_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module sgbu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/softmax_gradient_bandit_update_core.sv
// Softmax gradient bandit update core; uses sgbu_pkg and sgbu_ram.
// Load item: result registered in S_LOAD, entered at the accepting edge.
// Update item: a maximum pass, an exponential pass, a divide and baseline
// pass and an update pass over the n active arms, plus output stalls; the
// 36-step restoring divider per arm dominates. One item at a time.
// rst (synchronous): registers reset, then S_CLEAR clears the table.
module softmax_gradient_bandit_update_core
  import sgbu_pkg::*;
#(
  parameter int NUM_ARMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(NUM_ARMS);
  localparam int NW = $clog2(NUM_ARMS + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_MAX_RD, S_MAX_WT, S_MAX_ACC,
    S_EXP_RD, S_EXP_WT, S_EXP_M1, S_EXP_M2, S_EXP_M3, S_EXP_WR,
    S_DIV_RD, S_DIV_WT, S_DIV_RUN, S_BASE_RD, S_BASE_WT, S_BASE_ACC,
    S_DELTA, S_UPD_RD, S_UPD_WT, S_UPD_M1, S_UPD_M2, S_UPD_WR, S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [3:0]  active_arms;
  logic [15:0] step_size;
  logic [15:0] inv_temperature;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_arms     <= 4'd8;
      step_size       <= 16'd6554;
      inv_temperature <= 16'd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ACTIVE_ARMS: active_arms     <= pwdata[3:0];
        REG_STEP_SIZE:   step_size       <= pwdata[15:0];
        REG_INV_TEMP:    inv_temperature <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ACTIVE_ARMS: prdata = {28'd0, active_arms};
      REG_STEP_SIZE:   prdata = {16'd0, step_size};
      REG_INV_TEMP:    prdata = {16'd0, inv_temperature};
      default:         prdata = 32'd0;
    endcase
  end

  // Effective arm count: zero reads as one, capped at NUM_ARMS and 8
  logic [NW-1:0] n_eff;
  always_comb begin
    logic [4:0] c;
    c = (active_arms == 4'd0) ? 5'd1 : {1'b0, active_arms};
    if (c > 5'd8) c = 5'd8;
    if (32'(c) > NUM_ARMS) n_eff = NW'(NUM_ARMS);
    else n_eff = NW'(c);
  end

  // Memories
  logic                pt_we;
  logic [AW-1:0]       pt_waddr, pt_raddr;
  logic signed [15:0]  pt_wdata, pt_rdata;
  logic                eb_we;
  logic [15:0]         eb_wdata, eb_rdata;

  sgbu_ram #(.WIDTH(16), .DEPTH(NUM_ARMS)) u_pref (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  sgbu_ram #(.WIDTH(16), .DEPTH(NUM_ARMS)) u_exp (
    .clk(clk), .we(eb_we), .waddr(pt_waddr), .wdata(eb_wdata),
    .raddr(pt_raddr), .rdata(eb_rdata)
  );

  // Working registers
  in_item_t            item;
  logic [NW-1:0]       idx;
  logic [NW-1:0]       n_arms;
  logic signed [15:0]  max_preference;
  logic [19:0]         exp_sum;
  logic signed [31:0]  baseline_acc;
  logic signed [15:0]  h_reg;
  logic [31:0]         x_reg;
  logic [47:0]         y_reg;
  logic [16:0]         v_reg;
  logic [15:0]         prob_reg;
  logic [15:0]         probs [NUM_ARMS];
  logic [35:0]         div_rem;
  logic [35:0]         div_quo;
  logic [5:0]          div_cnt;
  logic signed [16:0]  delta;
  logic signed [33:0]  ad_reg;
  logic signed [51:0]  prod_reg;
  logic signed [15:0]  new_pref;
  logic                upd_last;
  logic                fwd_hit;
  logic [15:0]         fwd_data;

  assign pt_raddr = idx[AW-1:0];
  assign in_ready = (state == S_IDLE) && !out_valid;

  // Exponential fraction part from the registered scaled exponent
  logic [3:0]  ex_j;
  logic [13:0] ex_f;
  logic [16:0] t0, t1;
  logic [30:0] interp;
  assign ex_j   = y_reg[17:14];
  assign ex_f   = y_reg[13:0];
  assign t0     = pow2_tab({1'b0, ex_j});
  assign t1     = pow2_tab({1'b0, ex_j} + 5'd1);
  assign interp = 31'(t0 - t1) * 31'(ex_f);

  // Exponential result
  logic [15:0] e_val;
  always_comb begin
    logic [29:0] k;
    k = y_reg[47:18];
    if (k >= 30'd16) e_val = 16'd0;
    else e_val = 16'(v_reg >> (k[4:0] + 5'd1));
  end

  // Divider step: restoring, one quotient bit a cycle
  logic [36:0] div_trial;
  assign div_trial = {div_rem[35:0], div_quo[35]} - {17'd0, exp_sum};

  // Update step result with floor shift and saturation
  logic signed [17:0] h_new;
  always_comb begin
    logic signed [19:0] t;
    logic signed [19:0] s;
    t = 20'(prod_reg >>> 32);
    if (upd_last) s = 20'(h_reg) + t;
    else s = 20'(h_reg) - t;
    if (s > 20'sd32767) h_new = 18'sd32767;
    else if (s < -20'sd32768) h_new = -18'sd32768;
    else h_new = 18'(s);
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      idx            <= '0;
      out_valid      <= 1'b0;
      max_preference <= '0;
      exp_sum        <= '0;
      baseline_acc   <= '0;
      pt_we          <= 1'b0;
      eb_we          <= 1'b0;
      pt_waddr       <= '0;
      pt_wdata       <= '0;
    end else begin
      pt_we <= 1'b0;
      eb_we <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          pt_we    <= 1'b1;
          pt_waddr <= idx[AW-1:0];
          pt_wdata <= '0;
          if (idx == NW'(NUM_ARMS - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item   <= in_data;
            n_arms <= n_eff;
            idx    <= '0;
            state  <= in_data.mode ? S_LOAD : S_MAX_RD;
            max_preference <= '0;
          end
        end
        S_LOAD: begin
          out_data.out_arm     <= item.arm_index;
          out_data.probability <= '0;
          out_data.last        <= 1'b1;
          if (32'(item.arm_index) < NUM_ARMS) begin
            pt_we    <= 1'b1;
            pt_waddr <= AW'(item.arm_index);
            pt_wdata <= item.load_value;
            out_data.preference <= item.load_value;
          end else out_data.preference <= '0;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        // Maximum pass
        S_MAX_RD: state <= S_MAX_WT;
        S_MAX_WT: state <= S_MAX_ACC;
        S_MAX_ACC: begin
          if (pt_rdata > max_preference) max_preference <= pt_rdata;
          if (idx == n_arms - 1'b1) begin
            idx     <= '0;
            exp_sum <= '0;
            state   <= S_EXP_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MAX_RD;
          end
        end
        // Exponential pass
        S_EXP_RD: state <= S_EXP_WT;
        S_EXP_WT: state <= S_EXP_M1;
        S_EXP_M1: begin
          x_reg <= 16'(max_preference - pt_rdata) * inv_temperature;
          state <= S_EXP_M2;
        end
        S_EXP_M2: begin
          y_reg <= 48'((49'(x_reg) * 49'(LOG2E_Q16)) >> 16);
          state <= S_EXP_M3;
        end
        S_EXP_M3: begin
          v_reg <= t0 - 17'(interp >> 14);
          state <= S_EXP_WR;
        end
        S_EXP_WR: begin
          eb_we    <= 1'b1;
          pt_waddr <= idx[AW-1:0];
          eb_wdata <= e_val;
          exp_sum  <= exp_sum + 20'(e_val);
          if (idx == n_arms - 1'b1) begin
            idx   <= '0;
            state <= S_DIV_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_EXP_RD;
          end
        end
        // Probability pass; the last exponential write can land on the
        // entry read here, so it is forwarded
        S_DIV_RD: begin
          fwd_hit  <= eb_we && (pt_waddr == pt_raddr);
          fwd_data <= eb_wdata;
          state    <= S_DIV_WT;
        end
        S_DIV_WT: begin
          div_rem <= '0;
          div_quo <= {4'd0, (fwd_hit ? fwd_data : eb_rdata), 16'd0};
          div_cnt <= '0;
          state   <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          if (!div_trial[36]) begin
            div_rem <= div_trial[35:0];
            div_quo <= {div_quo[34:0], 1'b1};
          end else begin
            div_rem <= {div_rem[34:0], div_quo[35]};
            div_quo <= {div_quo[34:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd35) begin
            state <= S_BASE_RD;
          end
        end
        S_BASE_RD: begin
          if (exp_sum == 20'd0) prob_reg <= '0;
          else if (div_quo[35:16] != 20'd0) prob_reg <= 16'hFFFF;
          else prob_reg <= div_quo[15:0];
          state <= S_BASE_WT;
        end
        S_BASE_WT: state <= S_BASE_ACC;
        S_BASE_ACC: begin
          probs[idx[AW-1:0]] <= prob_reg;
          baseline_acc <= baseline_acc
                          + 32'($signed({1'b0, prob_reg}) * pt_rdata);
          if (idx == n_arms - 1'b1) begin
            idx   <= '0;
            state <= S_DELTA;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DIV_RD;
          end
        end
        S_DELTA: begin
          delta <= 17'(($signed({1'b0, item.reward, 26'd0}) - 34'(baseline_acc))
                       >>> 16);
          baseline_acc <= '0;
          state <= S_UPD_RD;
        end
        // Update pass
        S_UPD_RD: begin
          ad_reg <= $signed({1'b0, step_size}) * delta;
          state  <= S_UPD_WT;
        end
        S_UPD_WT: state <= S_UPD_M1;
        S_UPD_M1: begin
          h_reg    <= pt_rdata;
          upd_last <= (32'(idx) == 32'(item.arm_index));
          prob_reg <= probs[idx[AW-1:0]];
          state    <= S_UPD_M2;
        end
        S_UPD_M2: begin
          if (upd_last)
            prod_reg <= ad_reg * $signed({1'b0, 17'd65536 - 17'(prob_reg)});
          else
            prod_reg <= ad_reg * $signed({2'b0, prob_reg});
          state <= S_UPD_WR;
        end
        S_UPD_WR: begin
          new_pref <= 16'(h_new);
          pt_we    <= 1'b1;
          pt_waddr <= idx[AW-1:0];
          pt_wdata <= 16'(h_new);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_data.out_arm     <= 3'(idx);
            out_data.preference  <= new_pref;
            out_data.probability <= prob_reg;
            out_data.last        <= (idx == n_arms - 1'b1);
            out_valid <= 1'b1;
            if (idx == n_arms - 1'b1) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_UPD_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sgbu_checker.sv
// Port-level checker for the softmax gradient bandit update core.
// Uses sgbu_pkg; bound to the top level below.
module sgbu_checker
  import sgbu_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no item taken while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted with result pending");

  // a load item gives a last result with zero probability
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode |-> ##2 out_valid && out_data.last
      && out_data.probability == 16'd0)
    else $error("load result wrong");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind softmax_gradient_bandit_update_core sgbu_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data), .pready(pready)
);
